// ===== hdl/lbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types and constants of the LED bar level meter.
// ----------------------------------------------------------------------------
package lbm_pkg;

	localparam int MAX_LEDS = 64;
	localparam int LED_W    = $clog2(MAX_LEDS);
	localparam int H_W      = 7;
	localparam int LEVEL_W  = 16;
	localparam int BRIGHT_W = 10;
	localparam int IDX_W    = 14;
	localparam int COLOR_W  = 8;
	localparam int NUM_W    = 30;
	localparam int DVD_W    = 24;
	localparam int DSR_W    = 16;
	localparam int QUOT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_RENDER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRIP_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_NUMBER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd4;

	localparam logic [LEVEL_W-1:0] DECAY_STEP = 16'd100;
	localparam logic [COLOR_W-1:0] FULL_COLOR = 8'd255;
	localparam logic [COLOR_W-1:0] COLOR_CAP  = 8'd254;

	typedef struct packed {
		logic [H_W-1:0]      strip_height;
		logic [7:0]          bar_number;
		logic [LEVEL_W-1:0]  full_scale;
		logic [LEVEL_W-1:0]  floor_level;
		logic [BRIGHT_W-1:0] brightness;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_GMUL,
		ST_GCHK,
		ST_GDIV,
		ST_RDIV,
		ST_RGMUL,
		ST_RGDIV,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/lbm_if.sv =====
// ----------------------------------------------------------------------------
// lbm_if
// Valid/ready channels of the LED bar level meter.
// ----------------------------------------------------------------------------
interface lbm_in_if;
	import lbm_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [LEVEL_W-1:0] sample_level;
	modport source(output valid, func, sample_level, input ready);
	modport sink(input valid, func, sample_level, output ready);
endinterface

interface lbm_out_if;
	import lbm_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   led_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               last_led;
	modport source(output valid, led_index, red, green, blue, last_led, input ready);
	modport sink(input valid, led_index, red, green, blue, last_led, output ready);
endinterface

interface lbm_cfg_if;
	import lbm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/lbm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lbm_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module lbm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	lbm_cfg_if.sink       cfg,
	output lbm_pkg::cfg_t regs
);
	import lbm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.strip_height <= 7'd8;
			regs_q.bar_number   <= 8'd0;
			regs_q.full_scale   <= 16'hFFFF;
			regs_q.floor_level  <= 16'd0;
			regs_q.brightness   <= 10'd256;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_STRIP_HEIGHT: regs_q.strip_height <= cfg.data[H_W-1:0];
				REG_BAR_NUMBER:   regs_q.bar_number   <= cfg.data[7:0];
				REG_FULL_SCALE:   regs_q.full_scale   <= cfg.data;
				REG_FLOOR_LEVEL:  regs_q.floor_level  <= cfg.data;
				REG_BRIGHTNESS:   regs_q.brightness   <= cfg.data[BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/lbm_div.sv =====
// ----------------------------------------------------------------------------
// lbm_div
// Shared restoring divider, one quotient bit per cycle, 8-bit quotient.
// Dividend must be below divisor * 256.
// ----------------------------------------------------------------------------
module lbm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lbm_pkg::div_req_t req,
	output lbm_pkg::div_rsp_t rsp
);
	import lbm_pkg::*;

	logic              busy_q;
	logic [2:0]        cnt_q;
	logic [DVD_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dsr_q;
	logic [QUOT_W-2:0] quot_q;
	logic              ge;

	assign ge = rem_q >= dsr_q;

	assign rsp.busy     = busy_q;
	assign rsp.done     = busy_q && (cnt_q == 3'd0);
	assign rsp.quotient = {quot_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd7;
		end else if (busy_q) begin
			busy_q <= (cnt_q != 3'd0);
			cnt_q  <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dsr_q  <= {1'b0, req.divisor, 7'b0};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsr_q;
			dsr_q  <= {1'b0, dsr_q[DVD_W-1:1]};
			quot_q <= {quot_q[QUOT_W-3:0], ge};
		end
	end

endmodule

// ===== hdl/led_bar_level_meter.sv =====
// ----------------------------------------------------------------------------
// led_bar_level_meter
// One column of a peak-hold LED bar meter: level tracking and column render.
// ----------------------------------------------------------------------------
// Tick and add transactions update the held level in the accept cycle; the
// block is ready again the next cycle. A render transaction emits one result
// per LED (strip_height, capped at 64) and keeps the input blocked until the
// last one is loaded. All divisions share one divider: a fully lit LED needs
// one division (red), the LED where the bar ends three (green, red, red scaled
// by green), LEDs above it none, after one setup state; the result side can
// stall the render. Config is taken every cycle.
module led_bar_level_meter (
	input  logic      clk,
	input  logic      arst_n,
	lbm_in_if.sink    item,
	lbm_out_if.source result,
	lbm_cfg_if.sink   cfg
);
	import lbm_pkg::*;

	cfg_t     regs;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q, state_d;

	logic [LEVEL_W-1:0] bar_level_q;
	logic [LED_W-1:0]   i_q;
	logic               done_q;
	logic [NUM_W-1:0]   num_q;
	logic [IDX_W:0]     base_q;
	logic [COLOR_W-1:0] r_q, g_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   led_index_q;
	logic [COLOR_W-1:0] red_q, green_q;
	logic               last_q;

	logic [H_W-1:0]     h_eff, i_ext, span;
	logic [LEVEL_W-1:0] fs_eff, lowered;
	logic [14:0]        span255;
	logic [NUM_W-1:0]   num_d;
	logic               sat, last, out_free, in_acc;
	logic [13:0]        r_num;
	logic [15:0]        rg;
	logic [8:0]         bar1;
	logic [IDX_W:0]     base_prod;
	logic [IDX_W:0]     idx;
	logic [COLOR_W-1:0] g_net;
	logic [17:0]        r_sc, g_sc;

	lbm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign h_eff    = (regs.strip_height > H_W'(MAX_LEDS)) ? H_W'(MAX_LEDS) : regs.strip_height;
	assign fs_eff   = (regs.full_scale == '0) ? 16'd1 : regs.full_scale;
	assign i_ext    = H_W'(i_q);
	assign last     = H_W'(i_ext + 7'd1) == h_eff;
	assign span     = h_eff - i_ext;
	assign span255  = {span, 8'b0} - {8'b0, span};
	assign num_d    = NUM_W'(bar_level_q) * NUM_W'(span255);
	assign sat      = num_q >= {6'b0, fs_eff, 8'b0};
	assign r_num    = {i_ext, 7'b0} + {1'b0, i_ext, 6'b0} + {2'b0, i_ext, 5'b0}
	                + {3'b0, i_ext, 4'b0} + {4'b0, i_ext, 3'b0} + {5'b0, i_ext, 2'b0}
	                + {6'b0, i_ext, 1'b0} + {7'b0, i_ext};
	assign rg       = 16'(r_q) * 16'(g_q);
	assign out_free = !out_valid_q || result.ready;
	assign in_acc   = item.valid && item.ready;
	assign bar1     = {1'b0, regs.bar_number} + {8'b0, regs.bar_number[0]};
	assign base_prod = (IDX_W+1)'(h_eff) * (IDX_W+1)'(bar1);
	assign idx      = regs.bar_number[0] ? (base_q - (IDX_W+1)'(i_q))
	                                     : (base_q + (IDX_W+1)'(i_q));
	assign g_net    = g_q - r_q;
	assign r_sc     = 18'(r_q) * 18'(regs.brightness);
	assign g_sc     = 18'(g_net) * 18'(regs.brightness);
	assign lowered  = bar_level_q - DECAY_STEP;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && item.func == FUNC_RENDER) state_d = ST_START;
			ST_START: state_d = (h_eff == '0) ? ST_IDLE : ST_GMUL;
			ST_GMUL:  state_d = done_q ? ST_EMIT : ST_GCHK;
			ST_GCHK:  state_d = sat ? ST_RDIV : ST_GDIV;
			ST_GDIV:  if (div_rsp.done) state_d = ST_RDIV;
			ST_RDIV:  if (div_rsp.done) state_d = done_q ? ST_RGMUL : ST_EMIT;
			ST_RGMUL: state_d = ST_RGDIV;
			ST_RGDIV: if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = last ? ST_IDLE : ST_GMUL;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready       = (state_q == ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'(r_num);
		div_req.divisor  = DSR_W'(h_eff);
		unique case (state_q)
			ST_GCHK: begin
				div_req.start = 1'b1;
				if (!sat) begin
					div_req.dividend = num_q[DVD_W-1:0];
					div_req.divisor  = fs_eff;
				end
			end
			ST_GDIV: div_req.start = div_rsp.done;
			ST_RGMUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(rg);
				div_req.divisor  = DSR_W'(FULL_COLOR);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bar_level_q <= '0;
			i_q         <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				case (item.func)
					FUNC_TICK: begin
						if (bar_level_q < DECAY_STEP || lowered < regs.floor_level)
							bar_level_q <= regs.floor_level;
						else
							bar_level_q <= lowered;
					end
					FUNC_ADD:
						if (item.sample_level > bar_level_q)
							bar_level_q <= item.sample_level;
					default: ;
				endcase
			end
			if (state_q == ST_START) begin
				i_q    <= '0;
				done_q <= 1'b0;
			end
			if (state_q == ST_GDIV && div_rsp.done)
				done_q <= 1'b1;
			if (state_q == ST_EMIT && out_free)
				i_q <= i_q + LED_W'(1);
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: base_q <= base_prod - (IDX_W+1)'(regs.bar_number[0]);
			ST_GMUL: begin
				num_q <= num_d;
				if (done_q) begin
					r_q <= '0;
					g_q <= '0;
				end
			end
			ST_GCHK:  if (sat) g_q <= FULL_COLOR;
			ST_GDIV:  if (div_rsp.done) g_q <= div_rsp.quotient;
			ST_RDIV:  if (div_rsp.done) r_q <= div_rsp.quotient;
			ST_RGDIV: if (div_rsp.done) r_q <= div_rsp.quotient;
			default: ;
		endcase
		if (state_q == ST_EMIT && out_free) begin
			led_index_q <= idx[IDX_W-1:0];
			red_q       <= (r_sc[17:8] > 10'(COLOR_CAP)) ? COLOR_CAP : r_sc[15:8];
			green_q     <= (g_sc[17:8] > 10'(COLOR_CAP)) ? COLOR_CAP : g_sc[15:8];
			last_q      <= last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.led_index = led_index_q;
	assign result.red       = red_q;
	assign result.green     = green_q;
	assign result.blue      = '0;
	assign result.last_led  = last_q;

	a_level_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bar_level_q) |-> $past(item.valid && item.ready))
		else $error("bar level changed without an input transaction");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_GDIV || state_q == ST_RDIV || state_q == ST_RGDIV))
		else $error("divider running outside a divide state");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && result.valid && !result.ready) |=> state_q == ST_EMIT)
		else $error("result overwritten while stalled");

endmodule

// ===== dv/lbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_checker
// Follows register writes and level updates seen on the channels, works out
// every LED of each rendered column and compares it with the meter's output.
// ----------------------------------------------------------------------------
module lbm_checker (
	input  logic clk,
	input  logic arst_n,
	lbm_in_if    item,
	lbm_out_if   result,
	lbm_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   leds_seen
);
	import lbm_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]   led_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last_led;
	} led_t;

	cfg_t               settings;
	logic [LEVEL_W-1:0] level;
	led_t               column_leds[$];
	int                 fail_cnt = 0;
	int                 led_cnt = 0;

	function automatic logic [COLOR_W-1:0] apply_gain(input longint unsigned v);
		longint unsigned s;
		s = (v * settings.brightness) >> 8;
		return (s > COLOR_CAP) ? COLOR_CAP : s[COLOR_W-1:0];
	endfunction

	task automatic take_write();
		case (cfg.index)
		REG_STRIP_HEIGHT: settings.strip_height = cfg.data[H_W-1:0];
		REG_BAR_NUMBER:   settings.bar_number = cfg.data[7:0];
		REG_FULL_SCALE:   settings.full_scale = cfg.data;
		REG_FLOOR_LEVEL:  settings.floor_level = cfg.data;
		REG_BRIGHTNESS:   settings.brightness = cfg.data[BRIGHT_W-1:0];
		default: ;
		endcase
	endtask

	task automatic apply_tick();
		if (level < DECAY_STEP || level - DECAY_STEP < settings.floor_level) begin
			level = settings.floor_level;
		end else begin
			level = level - DECAY_STEP;
		end
	endtask

	task automatic render_column();
		longint unsigned h, fs, bar, i, g, r, idx;
		bit              lit_end;
		led_t            e;
		h = (settings.strip_height > MAX_LEDS) ? MAX_LEDS : settings.strip_height;
		fs = (settings.full_scale == 0) ? 1 : settings.full_scale;
		bar = settings.bar_number;
		lit_end = 0;
		for (i = 0; i < h; i++) begin
			idx = settings.bar_number[0] ? h * (bar + 1) - i - 1 : i + h * bar;
			e.red = '0;
			e.green = '0;
			if (!lit_end) begin
				g = level;
				g = g * FULL_COLOR * (h - i) / fs;
				if (g > FULL_COLOR) begin
					g = FULL_COLOR;
				end else begin
					lit_end = 1;
				end
				r = FULL_COLOR * i / h;
				// top of the bar: red fades with the partial green
				if (lit_end) begin
					r = r * g / FULL_COLOR;
				end
				g = g - r;
				e.red = apply_gain(r);
				e.green = apply_gain(g);
			end
			e.led_index = idx[IDX_W-1:0];
			e.blue = '0;
			e.last_led = (i + 1 == h);
			column_leds.insert(column_leds.size(), e);
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_led();
		led_t want;
		led_cnt++;
		if (column_leds.size() == 0) begin
			fail_cnt++;
			$display("%0t: LED transaction with none expected: idx %0d rgb %0d/%0d/%0d last %0b",
				$time, result.led_index, result.red, result.green, result.blue,
				result.last_led);
		end else begin
			want = column_leds.pop_front();
			compare_field("led_index", 16'(want.led_index), 16'(result.led_index));
			compare_field("red", 16'(want.red), 16'(result.red));
			compare_field("green", 16'(want.green), 16'(result.green));
			compare_field("blue", 16'(want.blue), 16'(result.blue));
			compare_field("last_led", 16'(want.last_led), 16'(result.last_led));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.strip_height = 7'd8;
			settings.bar_number = '0;
			settings.full_scale = '1;
			settings.floor_level = '0;
			settings.brightness = 10'd256;
			level = '0;
			column_leds.delete();
			errors <= fail_cnt;
			pending <= 0;
			leds_seen <= led_cnt;
		end else begin
			if (cfg.valid && cfg.ready) begin
				take_write();
			end
			if (result.valid && result.ready) begin
				check_led();
			end
			if (item.valid && item.ready) begin
				case (item.func)
				FUNC_TICK: apply_tick();
				FUNC_ADD: begin
					if (item.sample_level > level) begin
						level = item.sample_level;
					end
				end
				FUNC_RENDER: render_column();
				default: ;
				endcase
			end
			errors <= fail_cnt;
			pending <= column_leds.size();
			leds_seen <= led_cnt;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, add and render transactions and register settings into the LED
// bar level meter, with random idling on both channels and one long output
// hold-off; the checker beside the block predicts and compares every LED.
// ----------------------------------------------------------------------------
module tb_top;
	import lbm_pkg::*;

	localparam logic [1:0]           FUNC_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 55;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 32;
	localparam int STALL_LIMIT     = 3000;

	logic clk;
	logic arst_n;
	int   errors, pending, leds_seen;
	int   n_tick = 0, n_add = 0, n_render = 0, n_settings = 0;
	bit   idle_on = 1;
	bit   hold_req = 0;

	lbm_in_if  item_ch ();
	lbm_out_if led_ch ();
	lbm_cfg_if cfg_ch ();

	led_bar_level_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (led_ch),
		.cfg    (cfg_ch)
	);

	lbm_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (led_ch),
		.cfg       (cfg_ch),
		.errors    (errors),
		.pending   (pending),
		.leds_seen (leds_seen)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send(input logic [1:0] f, input logic [LEVEL_W-1:0] s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.sample_level <= s;
		do @(posedge clk); while (!item_ch.ready);
		case (f)
		FUNC_TICK:   n_tick++;
		FUNC_ADD:    n_add++;
		FUNC_RENDER: n_render++;
		default: ;
		endcase
	endtask

	task automatic quiesce();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// unused upper data bits carry junk; the spare index must be ignored
	task automatic load_settings(input logic [H_W-1:0] h, input logic [7:0] bar,
			input logic [LEVEL_W-1:0] fs, input logic [LEVEL_W-1:0] flr,
			input logic [BRIGHT_W-1:0] gain);
		int unsigned junk;
		quiesce();
		junk = $urandom;
		write_reg(REG_STRIP_HEIGHT, {junk[8:0], h});
		write_reg(REG_BAR_NUMBER, {junk[16:9], bar});
		write_reg(REG_FULL_SCALE, fs);
		write_reg(REG_FLOOR_LEVEL, flr);
		write_reg(REG_BRIGHTNESS, {junk[22:17], gain});
		write_reg(REG_SPARE, junk[31:16]);
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		int stall;
		stall = 0;
		led_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				led_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				stall = HOLD_CYCLES - 1;
				led_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				led_ch.ready <= 1'b0;
			end else begin
				led_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
					(led_ch.valid && led_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		int                  ph, k, pick;
		int unsigned         smax, rnd;
		logic [H_W-1:0]      h;
		logic [LEVEL_W-1:0]  fs, flr;
		logic [BRIGHT_W-1:0] gain;
		item_ch.valid <= 1'b0;
		item_ch.func <= FUNC_TICK;
		item_ch.sample_level <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_STRIP_HEIGHT;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, level starting from zero
		send(FUNC_TICK, 16'hFFFF);
		send(FUNC_RENDER, 16'h0000);
		send(FUNC_ADD, 16'd50);
		send(FUNC_TICK, 16'h0000);
		send(FUNC_ADD, 16'd3000);
		send(FUNC_ADD, 16'd2000);
		send(FUNC_RENDER, 16'hFFFF);
		send(FUNC_NONE, 16'hFFFF);
		// single LED, odd bar, zero full scale, floor above level, max gain
		load_settings(7'd1, 8'd255, 16'd0, 16'd4000, 10'd1023);
		send(FUNC_TICK, 16'h5A5A);
		send(FUNC_RENDER, 16'hA5A5);
		load_settings(7'd64, 8'd254, 16'd20000, 16'd0, 10'd0);
		send(FUNC_RENDER, 16'h0000);
		send(FUNC_TICK, 16'h0000);
		load_settings(7'd0, 8'd1, 16'd1, 16'd0, 10'd256);
		send(FUNC_RENDER, 16'h0000);
		load_settings(7'd127, 8'd1, 16'hFFFF, 16'd0, 10'd700);
		send(FUNC_RENDER, 16'h0000);
		send(FUNC_ADD, 16'd8000);
		send(FUNC_RENDER, 16'h0000);
		load_settings(7'd8, 8'd0, 16'd9000, 16'd0, 10'd256);
		send(FUNC_RENDER, 16'h0000);

		// level ceiling grows phase by phase so the bar top lands all over
		for (ph = 0; ph < PHASES; ph++) begin
			idle_on = (ph != 4 && ph != PHASES - 1);
			smax = (ph == PHASES - 1) ? 65535 : 3000 + ph * 9000;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				h = '0;
			end else if (pick < 20) begin
				h = H_W'(MAX_LEDS);
			end else if (pick < 30) begin
				h = H_W'($urandom_range(MAX_LEDS + 1, 127));
			end else if (pick < 45) begin
				h = H_W'($urandom_range(11, MAX_LEDS - 1));
			end else begin
				h = H_W'($urandom_range(1, 10));
			end
			if (ph == 1) begin
				h = H_W'(MAX_LEDS);
			end
			fs = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
			flr = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, smax));
			if (ph == PHASES - 1) begin
				flr = '1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				gain = '0;
			end else if (pick < 30) begin
				gain = '1;
			end else if (pick < 50) begin
				gain = 10'd256;
			end else begin
				gain = BRIGHT_W'($urandom_range(0, 1023));
			end
			rnd = $urandom;
			load_settings(h, rnd[7:0], fs, flr, gain);
			if (ph == PHASES - 1) begin
				send(FUNC_ADD, 16'hFFFF);
			end
			k = 0;
			while (k < ITEMS_PER_PHASE) begin
				if (ph == 1 && k == 8) begin
					hold_req = 1;
				end
				rnd = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					send(FUNC_NONE, rnd[15:0]);
				end else begin
					if (pick < 35) begin
						send(FUNC_TICK, rnd[15:0]);
					end else if (pick < 70) begin
						send(FUNC_ADD, 16'($urandom_range(0, smax)));
					end else begin
						send(FUNC_RENDER, rnd[15:0]);
					end
					k++;
				end
			end
		end

		quiesce();
		$display("tb_top: %0d ticks, %0d adds, %0d renders over %0d register settings",
			n_tick, n_add, n_render, n_settings);
		$display("tb_top: %0d LED transactions compared, %0d mismatches", leds_seen, errors);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
